FILE: sv/apsp_pkg.sv
// ----------------------------------------------------------------------------
// apsp_pkg: shared types and constants for the all-pairs shortest path block
// Holds the request/response beat layouts, the action codes, the stored cell
// layout and the distance range used by the relaxation unit.
// ----------------------------------------------------------------------------
package apsp_pkg;

   // distance range of one stored entry and of the response field
   localparam int DIST_WIDTH = 24;
   localparam logic signed [DIST_WIDTH-1:0] DIST_MAX = {1'b0, {(DIST_WIDTH-1){1'b1}}};
   localparam logic signed [DIST_WIDTH-1:0] DIST_MIN = {1'b1, {(DIST_WIDTH-1){1'b0}}};

   // default matrix size and node count after reset
   localparam int MAX_NODES_DEF = 16;
   localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_EDGE  = 2'd1,
      ACT_SOLVE = 2'd2,
      ACT_QUERY = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [3:0]          src_node;
      logic [3:0]          dst_node;
      logic signed [15:0]  edge_weight;
   } req_type;

   typedef struct packed {
      logic signed [DIST_WIDTH-1:0] distance;
      logic                         reachable;
   } rsp_type;

   // one matrix entry: reachable bit and signed length
   typedef struct packed {
      logic                         exists;
      logic signed [DIST_WIDTH-1:0] len;
   } cell_type;

   // result of one add/saturate/compare pass
   typedef struct packed {
      logic signed [DIST_WIDTH-1:0] sum;
      logic                         take;
   } relax_type;

endpackage

FILE: sv/apsp_mem.sv
// ----------------------------------------------------------------------------
// apsp_mem: distance matrix storage
// One write port and two registered read ports, addressed by {row, column}.
// ----------------------------------------------------------------------------
module apsp_mem #(
   parameter int ADDR_BITS = 8
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_BITS-1:0]   wr_addr,
   input  apsp_pkg::cell_type     wr_data,
   input  logic [ADDR_BITS-1:0]   rd_a_addr,
   output apsp_pkg::cell_type     rd_a_data,
   input  logic [ADDR_BITS-1:0]   rd_b_addr,
   output apsp_pkg::cell_type     rd_b_data
);
   import apsp_pkg::*;

   localparam int DEPTH = 1 << ADDR_BITS;

   cell_type store_ff [DEPTH];
   cell_type rd_a_ff;
   cell_type rd_b_ff;

   // write port and registered read ports (read returns the old contents)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= store_ff[rd_a_addr];
      rd_b_ff <= store_ff[rd_b_addr];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

FILE: sv/apsp_relax.sv
// ----------------------------------------------------------------------------
// apsp_relax: shared add, saturate and compare unit
// Adds two legs, clamps to the distance range and decides whether the sum
// replaces the target entry (target unreachable or sum strictly smaller).
// ----------------------------------------------------------------------------
module apsp_relax (
   input  logic signed [apsp_pkg::DIST_WIDTH-1:0] leg_a,
   input  logic signed [apsp_pkg::DIST_WIDTH-1:0] leg_b,
   input  apsp_pkg::cell_type                     target,
   output apsp_pkg::relax_type                    result
);
   import apsp_pkg::*;

   logic signed [DIST_WIDTH:0]   sum_wide;
   logic signed [DIST_WIDTH-1:0] sum_sat;

   // one extra bit catches overflow; clamp when the top two bits differ
   always_comb begin
      sum_wide = {leg_a[DIST_WIDTH-1], leg_a} + {leg_b[DIST_WIDTH-1], leg_b};
      if (sum_wide[DIST_WIDTH] != sum_wide[DIST_WIDTH-1]) begin
         sum_sat = sum_wide[DIST_WIDTH] ? DIST_MIN : DIST_MAX;
      end else begin
         sum_sat = sum_wide[DIST_WIDTH-1:0];
      end
   end

   assign result = '{sum: sum_sat, take: (!target.exists || (sum_sat < target.len))};

endmodule

FILE: sv/all_pairs_shortest_paths.sv
// ----------------------------------------------------------------------------
// all_pairs_shortest_paths: Floyd-Warshall distance matrix engine
// Keeps a MAX_NODES x MAX_NODES matrix of signed lengths with reachable bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat (clear, add edge, solve, query) under
//   valid/ready; rsp_* returns exactly one beat per command, in order.
//   Only queries return a nonzero distance and reachable flag.
//   csr_we/csr_wdata write node_count at any edge; write it only while idle.
// Steps per command (one at a time, req_ready low while busy):
//   edge or query: read, update and post steps from accept to rsp_valid.
//   clear: a write sweep over all 2**(2*clog2(MAX_NODES)) entries (256 at 16), then post.
//   solve: per (k, i) pair a read and check of i->k, plus a read and a
//   relax step per j when i->k is reachable, over the n live nodes.
//   The pace is set by the single shared add/compare unit and the one
//   matrix write port: each column is read, then relaxed, before the next.
// Reset: synchronous; node_count returns to 16 and the matrix is swept to
//   the cleared state before req_ready rises.
// Stall: a finished result waits in the response register; one more command
//   may be taken meanwhile, and the engine then holds in its last step until
//   the waiting beat is taken.
// ----------------------------------------------------------------------------
module all_pairs_shortest_paths #(
   parameter int MAX_NODES = apsp_pkg::MAX_NODES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  apsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output apsp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [4:0]        csr_wdata
);
   import apsp_pkg::*;

   localparam int NODE_BITS = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int ADDR_BITS = 2 * NODE_BITS;
   localparam int CNT_BITS  = $clog2(MAX_NODES + 1);
   localparam int CMP_BITS  = (CNT_BITS > 5) ? CNT_BITS : 5;

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_EDGE_RD,
      S_EDGE_WR,
      S_QRY_RD,
      S_QRY_OUT,
      S_IK_RD,
      S_IK_CHK,
      S_J_RD,
      S_J_CALC,
      S_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [4:0]                   node_count_ff, node_count_in;
   logic [ADDR_BITS-1:0]         sweep_ff, sweep_in;
   logic                         clr_pend_ff, clr_pend_in;
   logic [NODE_BITS-1:0]         src_row_ff, src_row_in;
   logic [NODE_BITS-1:0]         dst_row_ff, dst_row_in;
   logic signed [15:0]           weight_ff, weight_in;
   logic [NODE_BITS-1:0]         k_ff, k_in;
   logic [NODE_BITS-1:0]         i_ff, i_in;
   logic [NODE_BITS-1:0]         j_ff, j_in;
   logic signed [DIST_WIDTH-1:0] ik_len_ff, ik_len_in;
   rsp_type                      res_ff, res_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   logic [CMP_BITS-1:0]          live_n;
   logic [CMP_BITS-1:0]          last_n;
   logic [CMP_BITS-1:0]          src_ext;
   logic [CMP_BITS-1:0]          dst_ext;
   logic                         in_range;
   logic                         req_beat;

   logic                         mem_we;
   logic [ADDR_BITS-1:0]         mem_waddr;
   cell_type                     mem_wdata;
   logic [ADDR_BITS-1:0]         rd_a_addr;
   logic [ADDR_BITS-1:0]         rd_b_addr;
   cell_type                     rd_a_data;
   cell_type                     rd_b_data;

   logic signed [DIST_WIDTH-1:0] leg_a;
   logic signed [DIST_WIDTH-1:0] leg_b;
   relax_type                    relax;

   // matrix storage and the shared relaxation unit
   apsp_mem #(
      .ADDR_BITS (ADDR_BITS)
   ) u_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_a_addr (rd_a_addr),
      .rd_a_data (rd_a_data),
      .rd_b_addr (rd_b_addr),
      .rd_b_data (rd_b_data)
   );

   apsp_relax u_relax (
      .leg_a  (leg_a),
      .leg_b  (leg_b),
      .target (rd_b_data),
      .result (relax)
   );

   // live node count clamped to 1..MAX_NODES, and the request range check
   always_comb begin
      live_n = CMP_BITS'(node_count_ff);
      if (live_n == '0) begin
         live_n = CMP_BITS'(1);
      end else if (live_n > CMP_BITS'(MAX_NODES)) begin
         live_n = CMP_BITS'(MAX_NODES);
      end
      last_n   = live_n - CMP_BITS'(1);
      src_ext  = CMP_BITS'(req_data.src_node);
      dst_ext  = CMP_BITS'(req_data.dst_node);
      in_range = (src_ext < live_n) && (dst_ext < live_n);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_beat  = req_valid && req_ready;

   // unit operands: edge load compares the weight alone, solve adds two legs
   assign leg_a = (state_ff == S_EDGE_WR) ? DIST_WIDTH'(weight_ff) : ik_len_ff;
   assign leg_b = (state_ff == S_EDGE_WR) ? '0 : rd_a_data.len;

   // sequencer next state, memory control and result staging
   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_we ? csr_wdata : node_count_ff;
      sweep_in      = sweep_ff;
      clr_pend_in   = clr_pend_ff;
      src_row_in    = src_row_ff;
      dst_row_in    = dst_row_ff;
      weight_in     = weight_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ik_len_in     = ik_len_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      mem_we        = 1'b0;
      mem_waddr     = {i_ff, j_ff};
      mem_wdata     = '{exists: 1'b1, len: relax.sum};
      rd_a_addr     = {k_ff, j_ff};
      rd_b_addr     = {i_ff, j_ff};

      unique case (state_ff)
         S_SWEEP: begin
            mem_we           = 1'b1;
            mem_waddr        = sweep_ff;
            mem_wdata.exists = (sweep_ff[ADDR_BITS-1:NODE_BITS] == sweep_ff[NODE_BITS-1:0]);
            mem_wdata.len    = '0;
            sweep_in         = sweep_ff + ADDR_BITS'(1);
            if (sweep_ff == '1) begin
               state_in    = clr_pend_ff ? S_DONE : S_IDLE;
               clr_pend_in = 1'b0;
            end
         end
         S_IDLE: begin
            if (req_beat) begin
               src_row_in = src_ext[NODE_BITS-1:0];
               dst_row_in = dst_ext[NODE_BITS-1:0];
               weight_in  = req_data.edge_weight;
               res_in     = '0;
               k_in       = '0;
               i_in       = '0;
               j_in       = '0;
               unique case (req_data.action)
                  ACT_CLEAR: begin
                     sweep_in    = '0;
                     clr_pend_in = 1'b1;
                     state_in    = S_SWEEP;
                  end
                  ACT_EDGE:  state_in = in_range ? S_EDGE_RD : S_DONE;
                  ACT_SOLVE: state_in = S_IK_RD;
                  ACT_QUERY: state_in = in_range ? S_QRY_RD : S_DONE;
                  default:   state_in = S_DONE;
               endcase
            end
         end
         S_EDGE_RD: begin
            rd_b_addr = {src_row_ff, dst_row_ff};
            state_in  = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            mem_waddr = {src_row_ff, dst_row_ff};
            mem_we    = relax.take;
            state_in  = S_DONE;
         end
         S_QRY_RD: begin
            rd_b_addr = {src_row_ff, dst_row_ff};
            state_in  = S_QRY_OUT;
         end
         S_QRY_OUT: begin
            if (rd_b_data.exists) begin
               res_in.distance  = rd_b_data.len;
               res_in.reachable = 1'b1;
            end
            state_in = S_DONE;
         end
         S_IK_RD: begin
            rd_a_addr = {i_ff, k_ff};
            state_in  = S_IK_CHK;
         end
         S_IK_CHK: begin
            if (rd_a_data.exists) begin
               ik_len_in = rd_a_data.len;
               j_in      = '0;
               state_in  = S_J_RD;
            end else if (CMP_BITS'(i_ff) != last_n) begin
               i_in     = i_ff + NODE_BITS'(1);
               state_in = S_IK_RD;
            end else if (CMP_BITS'(k_ff) != last_n) begin
               k_in     = k_ff + NODE_BITS'(1);
               i_in     = '0;
               state_in = S_IK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_J_RD: begin
            state_in = S_J_CALC;
         end
         S_J_CALC: begin
            // port A holds k->j, port B holds i->j
            if (rd_a_data.exists && relax.take) begin
               mem_we = 1'b1;
               // writing i->k itself changes the first leg for later columns
               if (j_ff == k_ff) begin
                  ik_len_in = relax.sum;
               end
            end
            if (CMP_BITS'(j_ff) != last_n) begin
               j_in     = j_ff + NODE_BITS'(1);
               state_in = S_J_RD;
            end else if (CMP_BITS'(i_ff) != last_n) begin
               i_in     = i_ff + NODE_BITS'(1);
               state_in = S_IK_RD;
            end else if (CMP_BITS'(k_ff) != last_n) begin
               k_in     = k_ff + NODE_BITS'(1);
               i_in     = '0;
               state_in = S_IK_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         node_count_ff <= NODE_COUNT_RESET;
         sweep_ff      <= '0;
         clr_pend_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         sweep_ff      <= sweep_in;
         clr_pend_ff   <= clr_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      src_row_ff <= src_row_in;
      dst_row_ff <= dst_row_in;
      weight_ff  <= weight_in;
      k_ff       <= k_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      ik_len_ff  <= ik_len_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks on the sequencer
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("matrix written while idle");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("new command taken while busy");

   a_relax_needs_leg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_J_CALC && mem_we) |-> (rd_a_data.exists && mem_wdata.exists))
      else $error("relaxation through an unreachable leg");

   a_done_posts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) |=> rsp_valid)
      else $error("finished command posted no response");

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: all_pairs_shortest_paths
// Sends clear, edge, solve and query beats under random handshake gaps and
// checks every response beat against a distance-matrix predictor kept in the
// bench. Directed cases come first: cleared matrix, edge merge, node count
// clamping and a negative cycle driven into saturation. Random graph phases
// at several node counts follow.
// ----------------------------------------------------------------------------
module testbench;
   import apsp_pkg::*;

   localparam int NODES = MAX_NODES_DEF;
   localparam int CELLS = NODES * NODES;
   localparam int GRAPH_BEATS = 860;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_we;
   logic [4:0] csr_wdata;

   // predictor state: signed length and reachable bit per entry
   logic signed [DIST_WIDTH-1:0] dist_len [CELLS];
   bit                           dist_known [CELLS];
   logic [4:0]                   node_count_q;

   rsp_type awaited_answers [$];
   rsp_type head_answer;
   int      mismatch_count = 0;
   int      sent_beats = 0;
   int      stall_left = 0;
   bit      sender_calm;
   bit      receiver_calm;

   all_pairs_shortest_paths i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic int live_count();
      int n;
      n = int'(node_count_q);
      if (n < 1) n = 1;
      if (n > NODES) n = NODES;
      return n;
   endfunction

   function automatic logic signed [DIST_WIDTH-1:0] clip_dist(input longint v);
      if (v > longint'(DIST_MAX)) return DIST_MAX;
      if (v < longint'(DIST_MIN)) return DIST_MIN;
      return v[DIST_WIDTH-1:0];
   endfunction

   function automatic void wipe_matrix();
      for (int c = 0; c < CELLS; c++) begin
         dist_len[c]   = '0;
         dist_known[c] = (c / NODES) == (c % NODES);
      end
   endfunction

   // update the matrix for one command and return the response it must give
   function automatic rsp_type apply_command(input req_type beat);
      rsp_type answer;
      int      n, pair_idx, ik, kj, ij;
      bit      in_range;
      logic signed [DIST_WIDTH-1:0] w, s;
      answer   = '0;
      n        = live_count();
      in_range = (int'(beat.src_node) < n) && (int'(beat.dst_node) < n);
      pair_idx = int'(beat.src_node) * NODES + int'(beat.dst_node);
      case (beat.action)
         ACT_CLEAR: begin
            wipe_matrix();
         end
         ACT_EDGE: begin
            w = clip_dist(longint'(beat.edge_weight));
            if (in_range && (!dist_known[pair_idx] || w < dist_len[pair_idx])) begin
               dist_len[pair_idx]   = w;
               dist_known[pair_idx] = 1'b1;
            end
         end
         ACT_SOLVE: begin
            // relax every pair through each intermediate node, in order
            for (int k = 0; k < n; k++) begin
               for (int i = 0; i < n; i++) begin
                  ik = i * NODES + k;
                  if (dist_known[ik]) begin
                     for (int j = 0; j < n; j++) begin
                        kj = k * NODES + j;
                        ij = i * NODES + j;
                        if (dist_known[kj]) begin
                           s = clip_dist(longint'(dist_len[ik]) + longint'(dist_len[kj]));
                           if (!dist_known[ij] || s < dist_len[ij]) begin
                              dist_len[ij]   = s;
                              dist_known[ij] = 1'b1;
                           end
                        end
                     end
                  end
               end
            end
         end
         default: begin
            if (in_range && dist_known[pair_idx]) begin
               answer.distance  = dist_len[pair_idx];
               answer.reachable = 1'b1;
            end
         end
      endcase
      return answer;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic int pick_pause();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   function automatic int sender_gap();
      if (sender_calm || $urandom_range(0, 99) < 55) return 0;
      return pick_pause();
   endfunction

   function automatic req_type make_beat(input action_type act, input int src,
                                         input int dst, input int weight);
      req_type beat;
      beat.action      = act;
      beat.src_node    = 4'(src);
      beat.dst_node    = 4'(dst);
      beat.edge_weight = 16'(weight);
      return beat;
   endfunction

   function automatic int pick_node(input int n);
      if ($urandom_range(0, 9) != 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, 15);
   endfunction

   function automatic int pick_weight(input bit allow_neg);
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return $urandom_range(0, 200);
      if (r < 65) return allow_neg ? -int'($urandom_range(1, 60)) : $urandom_range(0, 60);
      if (r < 85) return allow_neg ? int'($urandom_range(0, 65535)) - 32768
                                   : $urandom_range(0, 32767);
      case ($urandom_range(0, 3))
         0: return allow_neg ? -32768 : 0;
         1: return 32767;
         2: return 0;
         default: return allow_neg ? -1 : 1;
      endcase
   endfunction

   task automatic log_mismatch(input string what, input longint want, input longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch: %s expected %0d got %0d", what, want, got);
   endtask

   // one request beat; returns right after the accepting edge
   task automatic send_beat(input req_type beat);
      int gap;
      rsp_type answer;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
      sent_beats++;
      answer = apply_command(beat);
      awaited_answers.insert(awaited_answers.size(), answer);
   endtask

   // hold the sender off until every response is in and the block is idle
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_node_count(input logic [4:0] value);
      drain_pipeline();
      csr_we       <= 1'b1;
      csr_wdata    <= value;
      node_count_q  = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // matrix right after the reset sweep
   task automatic test_cleared_matrix();
      send_beat(make_beat(ACT_QUERY, 0, 0, 0));
      send_beat(make_beat(ACT_QUERY, 15, 0, -1));
   endtask

   // smaller weight wins on a pair, extreme weights, negative self edge
   task automatic test_edge_merge_and_solve();
      send_beat(make_beat(ACT_EDGE, 0, 1, 300));
      send_beat(make_beat(ACT_EDGE, 0, 1, 500));
      send_beat(make_beat(ACT_EDGE, 1, 2, -32768));
      send_beat(make_beat(ACT_EDGE, 2, 3, 32767));
      send_beat(make_beat(ACT_EDGE, 3, 3, -1));
      send_beat(make_beat(ACT_SOLVE, 15, 15, 32767));
      send_beat(make_beat(ACT_QUERY, 0, 3, 0));
      send_beat(make_beat(ACT_QUERY, 3, 3, 0));
   endtask

   // counts above the matrix clamp down; indices past the count are ignored
   task automatic test_count_clamp();
      write_node_count(5'd31);
      send_beat(make_beat(ACT_QUERY, 15, 15, 0));
      write_node_count(5'd2);
      send_beat(make_beat(ACT_EDGE, 2, 0, 5));
      send_beat(make_beat(ACT_QUERY, 0, 2, 0));
      write_node_count(5'd16);
      send_beat(make_beat(ACT_QUERY, 2, 0, 0));
   endtask

   // count zero acts as one node; a negative self loop doubles per solve
   // until the sum pins at the bottom of the distance range
   task automatic test_negative_cycle();
      write_node_count(5'd0);
      send_beat(make_beat(ACT_CLEAR, 7, 9, 123));
      send_beat(make_beat(ACT_EDGE, 0, 0, -32768));
      repeat (9) send_beat(make_beat(ACT_SOLVE, 0, 0, 0));
      send_beat(make_beat(ACT_QUERY, 0, 0, 0));
      send_beat(make_beat(ACT_QUERY, 1, 1, 0));
   endtask

   // one random graph: load edges, solve, read back, some noise
   task automatic run_graph_phase(input int phase);
      bit big, allow_neg;
      int cnt, n, pick, rounds;
      big = (phase % 8) == 7;
      if (big) begin
         pick = $urandom_range(0, 2);
         cnt  = (pick == 0) ? 16 : (pick == 1) ? 31 : $urandom_range(17, 30);
      end else begin
         cnt = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(0, 8);
      end
      sender_calm   = $urandom_range(0, 4) == 0;
      receiver_calm = $urandom_range(0, 4) == 0;
      write_node_count(5'(cnt));
      n         = live_count();
      allow_neg = 1'($urandom_range(0, 1));
      if (phase == 0 || $urandom_range(0, 99) < 60)
         send_beat(make_beat(ACT_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
                             pick_weight(1'b1)));
      rounds = big ? 1 : $urandom_range(1, 3);
      repeat (rounds) begin
         repeat ($urandom_range(1, 2 * n + 2))
            send_beat(make_beat(ACT_EDGE, pick_node(n), pick_node(n), pick_weight(allow_neg)));
         if ($urandom_range(0, 9) == 0) drain_pipeline();
         send_beat(make_beat(ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15),
                             pick_weight(1'b1)));
         repeat ($urandom_range(n, 3 * n))
            send_beat(make_beat(ACT_QUERY, pick_node(n), pick_node(n), pick_weight(1'b1)));
      end
      if (!big && $urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 6))
            send_beat(make_beat(action_type'($urandom_range(0, 3)), $urandom_range(0, 15),
                                $urandom_range(0, 15), pick_weight(1'b1)));
      end
   endtask

   task automatic test_random_graphs();
      int stop_at, phase;
      stop_at = sent_beats + GRAPH_BEATS;
      phase   = 0;
      while (sent_beats < stop_at) begin
         run_graph_phase(phase);
         phase++;
      end
   endtask

   // ---------------------------------------------------------------- response side

   // random back-pressure, with calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (!receiver_calm && $urandom_range(0, 99) < 25) begin
         rsp_ready <= 1'b0;
         stall_left = pick_pause() - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each response beat with the oldest awaited answer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            log_mismatch("response with nothing awaited, distance", 0,
                         longint'(rsp_data.distance));
         end else begin
            head_answer = awaited_answers.pop_front();
            if (rsp_data.distance !== head_answer.distance)
               log_mismatch("distance", longint'(head_answer.distance),
                            longint'(rsp_data.distance));
            if (rsp_data.reachable !== head_answer.reachable)
               log_mismatch("reachable", longint'(head_answer.reachable),
                            longint'(rsp_data.reachable));
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      sender_calm   = 1'b0;
      receiver_calm = 1'b0;
      node_count_q  = NODE_COUNT_RESET;
      wipe_matrix();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_cleared_matrix();
      test_edge_merge_and_solve();
      test_count_clamp();
      test_negative_cycle();
      test_random_graphs();

      drain_pipeline();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #12000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
